// ===== hdl/hhe_pkg.sv =====
// Shared constants, types and character helpers for the HTTP Host header extractor.
// Depends on nothing; hhe_emitter and the top level refer to it by scoped names.
package hhe_pkg;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   // Length of the "host:" tag; the last tag byte is the colon.
   localparam logic [2:0] TAG_LEN = 3'd5;

   // Counts saturate at the top of their seven bits.
   localparam logic [6:0] COUNT_SAT = 7'd127;
   // The capacity register never acts above this value.
   localparam logic [6:0] CAP_CEIL  = 7'd64;
   localparam logic [6:0] CAP_RESET = 7'd64;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_NO_HOST   = 4'd1;
   localparam logic [3:0] ST_TRUNCATED = 4'd2;
   localparam logic [3:0] ST_BARE_CR   = 4'd3;
   localparam logic [3:0] ST_DUPLICATE = 4'd4;
   localparam logic [3:0] ST_EMPTY     = 4'd5;
   localparam logic [3:0] ST_BAD_PORT  = 4'd6;
   localparam logic [3:0] ST_TOO_LONG  = 4'd7;
   localparam logic [3:0] ST_BAD_CHAR  = 4'd8;

   // Command from the parser to the result sequencer.
   typedef struct packed {
      logic       fail;     // give one failure word with code
      logic       host;     // stream the buffered host, length bytes
      logic [3:0] code;
      logic [6:0] length;
   } start_type;

   function automatic logic [7:0] lower_byte(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_host_char(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
             is_digit(b) || (b == CHAR_DASH) || (b == CHAR_DOT);
   endfunction

   // Lower-case letters of the tag "host", by position.
   function automatic logic [7:0] tag_char(input logic [1:0] pos);
      logic [7:0] r;
      case (pos)
         2'd0: begin
            r = 8'h68;
         end
         2'd1: begin
            r = 8'h6F;
         end
         2'd2: begin
            r = 8'h73;
         end
         default: begin
            r = 8'h74;
         end
      endcase
      return r;
   endfunction

   function automatic logic [6:0] sat_add(input logic [6:0] a, input logic [6:0] b);
      logic [7:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, COUNT_SAT}) ? COUNT_SAT : s[6:0];
   endfunction

endpackage

// ===== hdl/hhe_channels.sv =====
// Valid/ready channel interfaces for the HTTP Host header extractor.
// Depends on nothing; field widths are fixed by the channel definitions.
interface hhe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_request;
   modport source (output valid, output data_byte, output end_of_request, input ready);
   modport sink   (input valid, input data_byte, input end_of_request, output ready);
endinterface

interface hhe_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] status;
   logic [7:0] host_char;
   logic [5:0] host_length;
   logic       last;
   modport source (output valid, output status, output host_char, output host_length,
                   output last, input ready);
   modport sink   (input valid, input status, input host_char, input host_length,
                   input last, output ready);
endinterface

interface hhe_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] host_capacity;
   modport source (output valid, output host_capacity, input ready);
   modport sink   (input valid, input host_capacity, output ready);
endinterface

// ===== hdl/hhe_emitter.sv =====
// Host buffer memory and result sequencer of the HTTP Host header extractor.
// Depends on hhe_pkg and the channel interfaces in hhe_channels.sv.
module hhe_emitter #(
   parameter int HOST_MAX = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [$clog2(HOST_MAX)-1:0] wr_addr,
   input  logic [7:0]                  wr_data,
   input  hhe_pkg::start_type          start,
   output logic                        busy,
   hhe_rsp_if.source                   rsp_bus
);

   localparam int AW = $clog2(HOST_MAX);

   logic [7:0]    mem [HOST_MAX];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [6:0]    rem_ff, rem_in;
   logic [5:0]    len_ff, len_in;

   // Staging word between the memory read and the output register.
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_host_ff, s1_host_in;
   logic [3:0]    s1_code_ff, s1_code_in;
   logic          s1_last_ff, s1_last_in;

   logic          out_valid_ff, out_valid_in;
   logic [3:0]    out_status_ff;
   logic [7:0]    out_char_ff;
   logic [5:0]    out_len_ff;
   logic          out_last_ff;

   logic          s1_move;
   logic          rd_issue;

   assign s1_move  = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign rd_issue = (rem_ff != 7'd0) && (!s1_valid_ff || s1_move);
   assign busy     = (rem_ff != 7'd0) || s1_valid_ff;

   always_comb begin
      rd_addr_in   = rd_addr_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      s1_valid_in  = s1_valid_ff;
      s1_host_in   = s1_host_ff;
      s1_code_in   = s1_code_ff;
      s1_last_in   = s1_last_ff;
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         s1_valid_in  = 1'b0;
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (rd_issue) begin
         s1_valid_in = 1'b1;
         s1_host_in  = 1'b1;
         s1_code_in  = hhe_pkg::ST_OK;
         s1_last_in  = (rem_ff == 7'd1);
         rd_addr_in  = rd_addr_ff + AW'(1);
         rem_in      = rem_ff - 7'd1;
      end
      if (start.fail) begin
         s1_valid_in = 1'b1;
         s1_host_in  = 1'b0;
         s1_code_in  = start.code;
         s1_last_in  = 1'b1;
      end else if (start.host) begin
         rem_in     = start.length;
         len_in     = start.length[5:0];
         rd_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= 7'd0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      rd_addr_ff <= rd_addr_in;
      len_ff     <= len_in;
      s1_host_ff <= s1_host_in;
      s1_code_ff <= s1_code_in;
      s1_last_ff <= s1_last_in;
      if (s1_move) begin
         out_status_ff <= s1_code_ff;
         out_char_ff   <= s1_host_ff ? rd_data_ff : 8'd0;
         out_len_ff    <= s1_host_ff ? len_ff : 6'd0;
         out_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.status      = out_status_ff;
   assign rsp_bus.host_char   = out_char_ff;
   assign rsp_bus.host_length = out_len_ff;
   assign rsp_bus.last        = out_last_ff;

endmodule

// ===== hdl/http_host_header_extractor.sv =====
// Top level of the HTTP Host header extractor: byte parser and capacity register.
// Depends on hhe_pkg, the interfaces in hhe_channels.sv and hhe_emitter.
//
// The block takes an HTTP request one byte per word on req_bus, with end_of_request
// set on the final byte, and finds the Host header. The request line is skipped; each
// header line is matched against "host:" without regard to case, the value is trimmed
// of blanks, an all-digit port after the first colon is dropped, and the host name is
// checked and stored lower-cased in an on-chip buffer of HOST_MAX bytes. At the blank
// line that closes the headers the host comes out on rsp_bus one byte per word, with
// its length on every word and last on the final one; any failure, including a request
// that ends early, gives a single word whose status names the cause. After a result
// is given, the rest of the request is consumed silently. The capacity register on
// csr_bus (reset 64) bounds the host length: it must be below the capacity, which
// acts as at most 64 and at most HOST_MAX; below two, every request answers "too
// long". Timing: parsing takes one byte per clock cycle while the result sequencer
// is not busy. The byte that completes a decision holds off the next input byte
// while its result words leave through the buffer's single read port, and longer
// if rsp_bus.ready is held low. The buffer needs no clearing after reset.
module http_host_header_extractor #(
   parameter int HOST_MAX = 64
) (
   input  logic      clock,
   input  logic      reset,
   hhe_req_if.sink   req_bus,
   hhe_rsp_if.source rsp_bus,
   hhe_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(HOST_MAX);
   localparam logic [6:0] CAP_LIMIT = 7'((HOST_MAX < 64) ? HOST_MAX : 64);
   localparam logic [8:0] BUF_DEPTH = 9'(HOST_MAX);

   typedef enum logic [2:0] {
      PH_REQ, PH_PREFIX, PH_SKIP, PH_LEAD, PH_HOST, PH_PORT, PH_CR
   } phase_type;

   phase_type  phase_ff, phase_in;
   phase_type  saved_ff, saved_in;
   logic [2:0] prefix_ff, prefix_in;
   logic       found_ff, found_in;
   logic [3:0] pend_ff, pend_in;
   logic [6:0] count_ff, count_in;
   logic [6:0] space_ff, space_in;
   logic       trail_ff, trail_in;
   logic       decided_ff, decided_in;
   logic       badc_ff, badc_in;
   logic       badp_ff, badp_in;
   logic [6:0] cap_ff;

   logic       busy;
   logic       accept;
   logic [6:0] cap_eff;
   logic [7:0] b;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [7:0]           wr_data;
   hhe_pkg::start_type   start;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !busy;
   assign accept        = req_bus.valid && !busy;
   assign b             = req_bus.data_byte;
   assign cap_eff       = (cap_ff > CAP_LIMIT) ? CAP_LIMIT : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= hhe_pkg::CAP_RESET;
      end else if (csr_bus.valid) begin
         cap_ff <= csr_bus.host_capacity;
      end
   end

   // Next-state logic of the parser. Steps are taken in the order the header
   // grammar demands: line endings first, then the per-phase byte handling,
   // then the host byte store, then the line-end decision.
   always_comb begin
      logic      gave;
      logic      do_end;
      logic      do_hb;
      logic      colon;
      phase_type kind;
      logic [3:0] code;

      phase_in   = phase_ff;
      saved_in   = saved_ff;
      prefix_in  = prefix_ff;
      found_in   = found_ff;
      pend_in    = pend_ff;
      count_in   = count_ff;
      space_in   = space_ff;
      trail_in   = trail_ff;
      decided_in = decided_ff;
      badc_in    = badc_ff;
      badp_in    = badp_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = hhe_pkg::lower_byte(b);
      start      = '0;
      gave       = 1'b0;
      do_end     = 1'b0;
      do_hb      = 1'b0;
      colon      = 1'b0;
      kind       = phase_ff;
      code       = hhe_pkg::ST_OK;

      if (accept && cap_eff >= 7'd2 && !decided_ff) begin
         if (phase_ff == PH_CR) begin
            if (b == hhe_pkg::CHAR_LF) begin
               do_end = 1'b1;
               kind   = saved_ff;
            end else begin
               gave       = 1'b1;
               start.fail = 1'b1;
               start.code = hhe_pkg::ST_BARE_CR;
            end
         end else if (b == hhe_pkg::CHAR_CR) begin
            saved_in = phase_ff;
            phase_in = PH_CR;
         end else if (b == hhe_pkg::CHAR_LF) begin
            do_end = 1'b1;
         end else begin
            case (phase_ff)
               PH_REQ: begin
                  prefix_in = 3'd1;
               end
               PH_PREFIX: begin
                  if ((prefix_ff < 3'd4) ?
                      (hhe_pkg::lower_byte(b) == hhe_pkg::tag_char(prefix_ff[1:0])) :
                      ((prefix_ff == 3'd4) && (b == hhe_pkg::CHAR_COLON))) begin
                     prefix_in = prefix_ff + 3'd1;
                     if (prefix_in == hhe_pkg::TAG_LEN) begin
                        if (found_ff) begin
                           pend_in  = hhe_pkg::ST_DUPLICATE;
                           phase_in = PH_SKIP;
                        end else begin
                           phase_in = PH_LEAD;
                           count_in = 7'd0;
                           space_in = 7'd0;
                           trail_in = 1'b0;
                           badc_in  = 1'b0;
                           badp_in  = 1'b0;
                        end
                     end
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_LEAD: begin
                  if (b == hhe_pkg::CHAR_COLON) begin
                     phase_in = PH_PORT;
                  end else if (!hhe_pkg::is_blank(b)) begin
                     phase_in = PH_HOST;
                     do_hb    = 1'b1;
                  end
               end
               PH_HOST: begin
                  if (hhe_pkg::is_blank(b)) begin
                     space_in = hhe_pkg::sat_add(space_ff, 7'd1);
                     trail_in = 1'b1;
                  end else if (b == hhe_pkg::CHAR_COLON) begin
                     // Blanks inside the host before the port count as bad characters.
                     if (space_ff != 7'd0) begin
                        count_in = hhe_pkg::sat_add(count_ff, space_ff);
                        badc_in  = 1'b1;
                     end
                     space_in = 7'd0;
                     trail_in = 1'b0;
                     phase_in = PH_PORT;
                  end else begin
                     do_hb = 1'b1;
                  end
               end
               PH_PORT: begin
                  if (hhe_pkg::is_blank(b)) begin
                     trail_in = 1'b1;
                  end else begin
                     if (trail_ff || !hhe_pkg::is_digit(b)) begin
                        badp_in = 1'b1;
                     end
                     trail_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end

         // Store one host byte; a pending run of blanks first joins the host.
         if (do_hb) begin
            if (space_ff != 7'd0) begin
               count_in = hhe_pkg::sat_add(count_in, space_ff);
               badc_in  = 1'b1;
               space_in = 7'd0;
               trail_in = 1'b0;
            end
            if (!hhe_pkg::is_host_char(b)) begin
               badc_in = 1'b1;
            end else if ({2'b00, count_in} < BUF_DEPTH) begin
               wr_en   = 1'b1;
               wr_addr = AW'(count_in);
            end
            count_in = hhe_pkg::sat_add(count_in, 7'd1);
         end

         if (do_end) begin
            case (kind)
               PH_REQ: begin
                  if (prefix_ff == 3'd0) begin
                     gave       = 1'b1;
                     start.fail = 1'b1;
                     start.code = hhe_pkg::ST_NO_HOST;
                  end
               end
               PH_PREFIX: begin
                  // An empty line closes the headers.
                  if (prefix_ff == 3'd0) begin
                     gave = 1'b1;
                     if (found_ff && count_ff != 7'd0) begin
                        start.host   = 1'b1;
                        start.length = count_ff;
                     end else begin
                        start.fail = 1'b1;
                        start.code = hhe_pkg::ST_NO_HOST;
                     end
                  end
               end
               PH_SKIP: begin
                  if (pend_ff != hhe_pkg::ST_OK) begin
                     gave       = 1'b1;
                     start.fail = 1'b1;
                     start.code = pend_ff;
                  end
               end
               PH_LEAD, PH_HOST, PH_PORT: begin
                  colon = (kind == PH_PORT);
                  if (colon && count_ff == 7'd0) begin
                     code = hhe_pkg::ST_EMPTY;
                  end else if (colon && badp_ff) begin
                     code = hhe_pkg::ST_BAD_PORT;
                  end else if (count_ff == 7'd0) begin
                     code = hhe_pkg::ST_EMPTY;
                  end else if (count_ff >= cap_eff) begin
                     code = hhe_pkg::ST_TOO_LONG;
                  end else if (badc_ff) begin
                     code = hhe_pkg::ST_BAD_CHAR;
                  end
                  if (code != hhe_pkg::ST_OK) begin
                     gave       = 1'b1;
                     start.fail = 1'b1;
                     start.code = code;
                  end else begin
                     found_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (!gave) begin
               phase_in  = PH_PREFIX;
               prefix_in = 3'd0;
            end
         end
         if (gave) begin
            decided_in = 1'b1;
         end
      end

      // The final byte settles any open request and clears the parse state.
      if (accept && req_bus.end_of_request) begin
         if (!decided_ff && !gave) begin
            start.fail = 1'b1;
            start.code = (cap_eff < 7'd2) ? hhe_pkg::ST_TOO_LONG : hhe_pkg::ST_TRUNCATED;
         end
         phase_in   = PH_REQ;
         saved_in   = PH_REQ;
         prefix_in  = 3'd0;
         found_in   = 1'b0;
         pend_in    = hhe_pkg::ST_OK;
         count_in   = 7'd0;
         space_in   = 7'd0;
         trail_in   = 1'b0;
         decided_in = 1'b0;
         badc_in    = 1'b0;
         badp_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_REQ;
         saved_ff   <= PH_REQ;
         prefix_ff  <= 3'd0;
         found_ff   <= 1'b0;
         pend_ff    <= hhe_pkg::ST_OK;
         count_ff   <= 7'd0;
         space_ff   <= 7'd0;
         trail_ff   <= 1'b0;
         decided_ff <= 1'b0;
         badc_ff    <= 1'b0;
         badp_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         saved_ff   <= saved_in;
         prefix_ff  <= prefix_in;
         found_ff   <= found_in;
         pend_ff    <= pend_in;
         count_ff   <= count_in;
         space_ff   <= space_in;
         trail_ff   <= trail_in;
         decided_ff <= decided_in;
         badc_ff    <= badc_in;
         badp_ff    <= badp_in;
      end
   end

   hhe_emitter #(
      .HOST_MAX (HOST_MAX)
   ) u_emitter (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .start   (start),
      .busy    (busy),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== dv/http_host_header_extractor_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for http_host_header_extractor: HTTP requests go in one byte
// per word, and every Host result word is predicted in-line and checked in order.
// Depends on hhe_pkg, the channel interfaces in hdl/hhe_channels.sv and the block's RTL.
module http_host_header_extractor_tb;
   import hhe_pkg::*;

   localparam int HOST_MAX      = 64;
   localparam int CYCLE_LIMIT   = 400000;
   // The longest result run is 63 words, so this covers any tail.
   localparam int SETTLE_CYCLES = 100;
   localparam int LONG_HOLD     = 400;
   localparam logic [31:0] TAG_TEXT = "host";

   // Line parser phases of the prediction.
   typedef enum logic [2:0] {
      PH_REQUEST, PH_TAG, PH_SKIP, PH_LEAD, PH_NAME, PH_PORT, PH_CR
   } phase_e;

   typedef struct packed {
      logic [7:0] data;
      logic       eor;
   } req_word_t;

   typedef struct packed {
      logic [3:0] status;
      logic [7:0] host_char;
      logic [5:0] host_length;
      logic       last;
   } rsp_word_t;

   logic clock = 1'b0;
   logic reset;

   hhe_req_if req_bus();
   hhe_rsp_if rsp_bus();
   hhe_csr_if csr_bus();

   http_host_header_extractor #(.HOST_MAX(HOST_MAX)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bytes waiting for the driver, and result words still owed by the block.
   req_word_t  bytes_to_send[$];
   rsp_word_t  words_due[$];
   logic [7:0] draft[$];
   int         bytes_queued   = 0;

   int   send_idle_pct  = 16;
   int   recv_stall_pct = 16;
   logic hold_request   = 1'b0;
   logic hold_taken;
   int   hold_left;
   int   mismatch_count = 0;
   int   cycle_count    = 0;

   // Host extractor state as the prediction sees it. The capacity register survives
   // the per-request clear; everything else is cleared on the final byte.
   logic [6:0] capacity_reg = CAP_RESET;
   phase_e     line_phase   = PH_REQUEST;
   phase_e     phase_at_cr  = PH_REQUEST;
   logic [2:0] tag_pos      = '0;
   logic       host_seen    = 1'b0;
   logic [3:0] held_error   = '0;
   logic [7:0] name_buf [HOST_MAX];
   logic [6:0] name_count   = '0;
   logic [6:0] blank_run    = '0;
   logic       blank_after  = 1'b0;
   logic       decided      = 1'b0;
   logic       name_bad     = 1'b0;
   logic       port_bad     = 1'b0;

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
   endfunction

   function automatic logic is_space_or_tab(input logic [7:0] b);
      return b == CHAR_SPACE || b == CHAR_TAB;
   endfunction

   function automatic logic [6:0] add_sat(input logic [6:0] a, input logic [6:0] b);
      int s;
      s = int'(a) + int'(b);
      return (s > int'(COUNT_SAT)) ? COUNT_SAT : 7'(s);
   endfunction

   // The register acts as at most 64 and at most the buffer size.
   function automatic int effective_capacity(input logic [6:0] c);
      int e;
      e = int'(c);
      if (e > int'(CAP_CEIL)) e = int'(CAP_CEIL);
      if (e > HOST_MAX) e = HOST_MAX;
      return e;
   endfunction

   task automatic give_status(input logic [3:0] code);
      rsp_word_t w;
      w.status      = code;
      w.host_char   = '0;
      w.host_length = '0;
      w.last        = 1'b1;
      words_due.push_back(w);
      decided = 1'b1;
   endtask

   task automatic open_line();
      line_phase = PH_TAG;
      tag_pos    = '0;
   endtask

   task automatic clear_request();
      line_phase  = PH_REQUEST;
      phase_at_cr = PH_REQUEST;
      tag_pos     = '0;
      host_seen   = 1'b0;
      held_error  = '0;
      name_count  = '0;
      blank_run   = '0;
      blank_after = 1'b0;
      decided     = 1'b0;
      name_bad    = 1'b0;
      port_bad    = 1'b0;
   endtask

   // A line has ended; what happens depends on the phase the line was in.
   task automatic close_line(input phase_e kind);
      logic [3:0] code;
      rsp_word_t  w;
      int         k;
      case (kind)
         PH_REQUEST: begin
            if (tag_pos == 0) give_status(ST_NO_HOST);
            else open_line();
         end
         PH_TAG: begin
            if (tag_pos != 0) begin
               open_line();
            end else if (host_seen && name_count != 0) begin
               // Blank line after a good Host line: stream the stored name.
               for (k = 0; k < int'(name_count); k++) begin
                  w.status      = ST_OK;
                  w.host_char   = (k < HOST_MAX) ? name_buf[k] : 8'h00;
                  w.host_length = name_count[5:0];
                  w.last        = (k + 1 == int'(name_count));
                  words_due.push_back(w);
               end
               decided = 1'b1;
            end else begin
               give_status(ST_NO_HOST);
            end
         end
         PH_SKIP: begin
            if (held_error != 0) give_status(held_error);
            else open_line();
         end
         PH_LEAD, PH_NAME, PH_PORT: begin
            code = ST_OK;
            if (kind == PH_PORT && name_count == 0) code = ST_EMPTY;
            else if (kind == PH_PORT && port_bad) code = ST_BAD_PORT;
            else if (name_count == 0) code = ST_EMPTY;
            else if (int'(name_count) + 1 > effective_capacity(capacity_reg)) code = ST_TOO_LONG;
            else if (name_bad) code = ST_BAD_CHAR;
            if (code != ST_OK) begin
               give_status(code);
            end else begin
               host_seen = 1'b1;
               open_line();
            end
         end
         default: begin
            open_line();
         end
      endcase
   endtask

   // A non-blank byte of the host value. Blanks held back so far were inside the
   // name after all, so they count toward the length and spoil the name.
   task automatic take_name_char(input logic [7:0] b);
      logic fits;
      fits = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
             (b >= "0" && b <= "9") || b == CHAR_DASH || b == CHAR_DOT;
      if (blank_run != 0) begin
         name_count  = add_sat(name_count, blank_run);
         name_bad    = 1'b1;
         blank_run   = '0;
         blank_after = 1'b0;
      end
      if (!fits) name_bad = 1'b1;
      else if (name_count < HOST_MAX) name_buf[name_count] = fold_case(b);
      name_count = add_sat(name_count, 7'd1);
   endtask

   // Works out the result words that one accepted request byte causes.
   task automatic predict_host_words(input logic [7:0] b, input logic eor);
      logic hit;
      logic small_cap;
      small_cap = effective_capacity(capacity_reg) < 2;
      if (!small_cap && !decided) begin
         if (line_phase == PH_CR) begin
            if (b == CHAR_LF) close_line(phase_at_cr);
            else give_status(ST_BARE_CR);
         end else if (b == CHAR_CR) begin
            phase_at_cr = line_phase;
            line_phase  = PH_CR;
         end else if (b == CHAR_LF) begin
            close_line(line_phase);
         end else begin
            case (line_phase)
               PH_REQUEST: begin
                  // Only marks the request line as non-empty.
                  tag_pos = 3'd1;
               end
               PH_TAG: begin
                  if (tag_pos < 3'd4) hit = fold_case(b) == TAG_TEXT[8*(3-int'(tag_pos)) +: 8];
                  else hit = b == CHAR_COLON;
                  if (!hit) begin
                     line_phase = PH_SKIP;
                  end else begin
                     tag_pos = tag_pos + 3'd1;
                     if (tag_pos == TAG_LEN) begin
                        if (host_seen) begin
                           held_error = ST_DUPLICATE;
                           line_phase = PH_SKIP;
                        end else begin
                           line_phase  = PH_LEAD;
                           name_count  = '0;
                           blank_run   = '0;
                           blank_after = 1'b0;
                           name_bad    = 1'b0;
                           port_bad    = 1'b0;
                        end
                     end
                  end
               end
               PH_LEAD: begin
                  if (!is_space_or_tab(b)) begin
                     if (b == CHAR_COLON) begin
                        line_phase = PH_PORT;
                     end else begin
                        line_phase = PH_NAME;
                        take_name_char(b);
                     end
                  end
               end
               PH_NAME: begin
                  if (is_space_or_tab(b)) begin
                     blank_run   = add_sat(blank_run, 7'd1);
                     blank_after = 1'b1;
                  end else if (b == CHAR_COLON) begin
                     if (blank_run != 0) begin
                        name_count = add_sat(name_count, blank_run);
                        name_bad   = 1'b1;
                     end
                     blank_run   = '0;
                     blank_after = 1'b0;
                     line_phase  = PH_PORT;
                  end else begin
                     take_name_char(b);
                  end
               end
               PH_PORT: begin
                  if (is_space_or_tab(b)) begin
                     blank_after = 1'b1;
                  end else begin
                     if (blank_after || b < "0" || b > "9") port_bad = 1'b1;
                     blank_after = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      if (eor) begin
         // A request that ends undecided answers once; below capacity two that
         // answer is "too long".
         if (!decided) give_status(small_cap ? ST_TOO_LONG : ST_TRUNCATED);
         clear_request();
      end
   endtask

   // Driver: offers the next pending byte whenever the channel slot is free, idling
   // at random.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid          <= 1'b1;
            req_bus.data_byte      <= bytes_to_send[0].data;
            req_bus.end_of_request <= bytes_to_send[0].eor;
            void'(bytes_to_send.pop_front());
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off counted below.
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_taken <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         hold_left  <= LONG_HOLD;
         hold_taken <= 1'b1;
      end
   end

   // Monitor: checks each accepted result word against the oldest expectation, then
   // predicts from the request byte accepted at the same edge. A word always comes
   // later than the byte that causes it, since it passes through the emitter's registers.
   always @(posedge clock) begin : monitor
      rsp_word_t got;
      rsp_word_t want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status      = rsp_bus.status;
            got.host_char   = rsp_bus.host_char;
            got.host_length = rsp_bus.host_length;
            got.last        = rsp_bus.last;
            if (words_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: status %0d char %02h length %0d last %0b",
                           got.status, got.host_char, got.host_length, got.last);
            end else begin
               want = words_due.pop_front();
               if (got.status !== want.status || got.host_char !== want.host_char ||
                   got.host_length !== want.host_length || got.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"word mismatch: expected status %0d char %02h length %0d ",
                               "last %0b, got status %0d char %02h length %0d last %0b"},
                              want.status, want.host_char, want.host_length, want.last,
                              got.status, got.host_char, got.host_length, got.last);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            predict_host_words(req_bus.data_byte, req_bus.end_of_request);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic put(input logic [7:0] b);
      draft.push_back(b);
   endtask

   // In directed text '^' stands for CR and '~' for LF.
   task automatic put_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         if (s[i] == "^") put(CHAR_CR);
         else if (s[i] == "~") put(CHAR_LF);
         else put(s[i]);
      end
   endtask

   // Moves the drafted request to the driver, flagging its last byte.
   task automatic send_draft();
      req_word_t w;
      while (draft.size() > 0) begin
         w.data = draft.pop_front();
         w.eor  = draft.size() == 0;
         bytes_to_send.push_back(w);
         bytes_queued++;
      end
   endtask

   task automatic send_text(input string s);
      put_text(s);
      send_draft();
   endtask

   function automatic logic [7:0] pick_name_char();
      string alphabet;
      alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-.";
      return alphabet[$urandom_range(alphabet.len() - 1)];
   endfunction

   task automatic put_blank();
      put($urandom_range(1) ? CHAR_TAB : CHAR_SPACE);
   endtask

   // Mostly CR LF, sometimes a bare LF, rarely a CR followed by something else.
   task automatic put_line_end();
      int r;
      r = $urandom_range(99);
      if (r < 3) begin
         put(CHAR_CR);
         put(pick_name_char());
      end else if (r < 20) begin
         put(CHAR_LF);
      end else begin
         put(CHAR_CR);
         put(CHAR_LF);
      end
   endtask

   task automatic put_host_line(input int cap_eff);
      int         k;
      int         len;
      int         r;
      int         broken;
      logic [7:0] b;
      broken = ($urandom_range(99) < 6) ? $urandom_range(4) : -1;
      for (k = 0; k < 5; k++) begin
         if (k == 4) b = CHAR_COLON;
         else b = TAG_TEXT[8*(3-k) +: 8] - ($urandom_range(1) ? 8'd32 : 8'd0);
         if (k == broken) b = pick_name_char();
         put(b);
      end
      repeat ($urandom_range(2)) put_blank();
      r = $urandom_range(99);
      if (r < 8) len = 0;
      else if (r < 25) len = cap_eff - 2 + $urandom_range(2);
      else if (r < 32) len = $urandom_range(70);
      else len = $urandom_range(1, 8);
      if (r >= 8 && len < 1) len = 1;
      for (k = 0; k < len; k++) begin
         if ($urandom_range(99) < 3) begin
            b = $urandom_range(255);
            if (b == CHAR_CR || b == CHAR_LF) b = CHAR_SPACE;
            put(b);
         end else begin
            put(pick_name_char());
         end
      end
      if ($urandom_range(99) < 25) begin
         put(CHAR_COLON);
         repeat ($urandom_range(5)) put(8'h30 + 8'($urandom_range(9)));
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(1)) put_blank();
            else put(pick_name_char());
            put(8'h38);
         end
      end
      repeat ($urandom_range(2)) put_blank();
      put_line_end();
   endtask

   // One random request: mostly well formed with random content, some noise, some
   // cut short.
   task automatic queue_random_request(input int cap_eff);
      int         lines;
      int         host_at;
      int         k;
      int         cut;
      logic [7:0] b;
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 12)) put($urandom_range(255));
      end else begin
         if ($urandom_range(99) >= 4) repeat ($urandom_range(1, 4)) put(pick_name_char());
         put_line_end();
         lines   = $urandom_range(3);
         host_at = ($urandom_range(99) < 85) ? $urandom_range(lines) : -1;
         for (k = 0; k <= lines; k++) begin
            if (k == host_at) put_host_line(cap_eff);
            if (k < lines) begin
               put_text("X-");
               repeat ($urandom_range(1, 4)) put(pick_name_char());
               put(CHAR_COLON);
               put_blank();
               repeat ($urandom_range(5)) begin
                  b = $urandom_range(255);
                  if (b == CHAR_CR || b == CHAR_LF) b = CHAR_DOT;
                  put(b);
               end
               put_line_end();
            end
         end
         if ($urandom_range(99) < 8) put_host_line(cap_eff);
         put_line_end();
         if ($urandom_range(99) < 10) repeat ($urandom_range(1, 4)) put($urandom_range(255));
         if ($urandom_range(99) < 8) begin
            cut = $urandom_range(draft.size() - 1);
            while (draft.size() > cut + 1) void'(draft.pop_back());
         end
      end
      send_draft();
   endtask

   // Waits until the block owes nothing, then lets it settle.
   task automatic wait_drained();
      do @(negedge clock);
      while (bytes_to_send.size() != 0 || req_bus.valid || words_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [6:0] value);
      @(posedge clock);
      csr_bus.host_capacity <= value;
      csr_bus.valid         <= 1'b1;
      do @(posedge clock);
      while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      capacity_reg  <= value;
      @(negedge clock);
   endtask

   // One capacity setting with random requests; optionally the receiver holds off
   // for a long stretch once the first request is on its way.
   task automatic run_phase(input logic [6:0] cap, input int byte_goal, input bit long_hold);
      int first;
      int requests;
      wait_drained();
      write_capacity(cap);
      first    = bytes_queued;
      requests = 0;
      while (bytes_queued - first < byte_goal || requests < 4) begin
         queue_random_request(effective_capacity(cap));
         requests++;
         if (long_hold) hold_request = 1'b1;
         while (bytes_to_send.size() > 64) @(negedge clock);
      end
   endtask

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.data_byte      = '0;
      req_bus.end_of_request = 1'b0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.host_capacity  = '0;
      reset                  = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_capacity(CAP_RESET);

      // Directed requests: one per outcome and per special case.
      send_text("GET / H^~Host: Ab-9.Z^~^~");
      send_text("G~hOsT:\t ab.c:8080 \t~~");
      send_text("G~Host: AZaz09-.~~");
      send_text("G^~X-Y: 1^~^~");
      send_text("~");
      send_text("G^~Host: a");
      send_text("G^");
      send_text("G^X~~");
      send_text("G~Host: a~HOST: b~~");
      send_text("G~Host: :80~~");
      send_text("G~Host: a:8x~~");
      send_text("G~Host: a:8 0~~");
      send_text("G~Host: \t~~");
      send_text("G~Host: a_b~~");
      send_text("G~Host: a b~~");
      send_text("G~Host;a~~");
      send_text("G~Host : a~~");
      send_text("G~Host: z~~tail");
      // All-zero and all-one bytes inside a header and after the blank line.
      put_text("G~X: ");
      put(8'h00);
      put(8'hFF);
      put_text("~Host: q~~");
      put(8'hFF);
      send_draft();
      // Longest host that fits the reset capacity, then one byte too many.
      put_text("G~Host: ");
      repeat (63) put(pick_name_char());
      put_text("~~");
      send_draft();
      put_text("G~Host: ");
      repeat (64) put(pick_name_char());
      put_text("~~");
      send_draft();

      run_phase(7'd64, 80, 1'b1);
      run_phase(7'd2, 40, 1'b0);
      run_phase(7'd127, 50, 1'b0);
      run_phase(7'd1, 15, 1'b0);
      run_phase(7'd0, 15, 1'b0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_phase(7'd64, 60, 1'b0);
      send_idle_pct  = 16;
      recv_stall_pct = 16;
      run_phase(7'($urandom_range(3, 63)), 50, 1'b0);
      wait_drained();

      if (mismatch_count == 0 && words_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/hhe_pkg.sv
hdl/hhe_channels.sv
hdl/hhe_emitter.sv
hdl/http_host_header_extractor.sv
dv/http_host_header_extractor_tb.sv
